### design/tccw_pkg.sv
// Shared types and constants of the text console character writer.
package tccw_pkg;

  // Operation codes carried with each input word.
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Control bytes that put-char interprets.
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_BLANK     = 8'd32;

  // Foreground of the blanks that fill the screen after reset.
  localparam logic [3:0] RESET_FG = 4'hF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic load_item;
    logic exec;
    logic write_cell;
    logic read_cell;
    logic copy_rd;
    logic scroll_start;
    logic drain;
    logic fill_wr;
    logic fill_reset;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic row_over;
    logic cnt_last;
    logic out_free;
  } status_t;

endpackage

### design/tccw_ctrl.sv
// Controller state machine of the text console character writer.
module tccw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tccw_pkg::status_t status,
  output tccw_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_WRITE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.fill_wr    = 1'b1;
        cmd.fill_reset = 1'b1;
        if (status.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (status.op)
          tccw_pkg::OP_PUT:   state_next = ST_WRITE;
          tccw_pkg::OP_SET:   state_next = ST_FINISH;
          tccw_pkg::OP_CLEAR: state_next = ST_FILL;
          tccw_pkg::OP_READ:  state_next = ST_READ;
          default:            state_next = ST_FINISH;
        endcase
      end
      ST_WRITE: begin
        cmd.write_cell = 1'b1;
        if (status.row_over) begin
          cmd.scroll_start = 1'b1;
          state_next       = ST_COPY;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.read_cell = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        if (status.cnt_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.drain  = 1'b1;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (status.cnt_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/tccw_datapath.sv
// Datapath of the text console character writer: cursor, cell store and output register.
module tccw_datapath #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  tccw_pkg::cmd_t    cmd,
  output tccw_pkg::status_t status,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_char_code,
  input  logic [4:0]        in_target_row,
  input  logic [6:0]        in_target_col,
  input  logic              cfg_valid,
  input  logic [3:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4:0]        out_cursor_row,
  output logic [6:0]        out_cursor_col,
  output logic [10:0]       out_cursor_index,
  output logic [7:0]        out_cell_char,
  output logic [7:0]        out_cell_attr
);

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int RW = $clog2(SCREEN_HEIGHT + 1);
  localparam int CW = $clog2(SCREEN_WIDTH + 1);

  // Cells hold the foreground nibble over the character byte; the background is always black.
  logic [11:0] cells [CELL_COUNT];

  tccw_pkg::op_t item_op;
  logic [7:0]    item_char;
  logic [4:0]    item_row;
  logic [6:0]    item_col;

  logic [3:0]    fg;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [AW-1:0] cnt;
  logic [AW-1:0] cell_addr;
  logic [11:0]   wr_data;
  logic          need_write;
  logic [11:0]   rd_data;
  logic          wb_valid;
  logic [AW-1:0] wb_addr;

  logic [RW-1:0] clamp_row;
  logic [CW-1:0] clamp_col;
  logic [RW-1:0] mul_row;
  logic [CW-1:0] mul_col;
  logic [AW-1:0] lin;
  logic [CW:0]   col_inc;
  logic [CW:0]   col_tab;
  logic [11:0]   fill_data;

  // Target position clamped to the screen.
  always_comb begin
    clamp_row = (32'(item_row) >= SCREEN_HEIGHT) ? RW'(SCREEN_HEIGHT - 1) : RW'(item_row);
    clamp_col = (32'(item_col) >= SCREEN_WIDTH) ? CW'(SCREEN_WIDTH - 1) : CW'(item_col);
  end

  // One shared multiplier turns a row and column into a linear cell index.
  always_comb begin
    mul_row = cur_row;
    mul_col = cur_col;
    if (cmd.exec && item_op == tccw_pkg::OP_READ) begin
      mul_row = clamp_row;
      mul_col = clamp_col;
    end else if (cmd.exec && item_char == tccw_pkg::CH_BACKSPACE) begin
      mul_col = cur_col - CW'(1);
    end
    lin = AW'(mul_row * SCREEN_WIDTH) + AW'(mul_col);
  end

  assign col_inc   = {1'b0, cur_col} + (CW + 1)'(1);
  assign col_tab   = ({1'b0, cur_col} | (CW + 1)'(3)) + (CW + 1)'(1);
  assign fill_data = cmd.fill_reset ? {tccw_pkg::RESET_FG, tccw_pkg::CH_BLANK}
                                    : {fg, tccw_pkg::CH_BLANK};

  assign status.op       = item_op;
  assign status.row_over = (32'(cur_row) == SCREEN_HEIGHT);
  assign status.cnt_last = (cnt == AW'(CELL_COUNT - 1));
  assign status.out_free = !out_valid || out_ready;

  // Input word and configuration register.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op   <= tccw_pkg::op_t'(in_operation);
      item_char <= in_char_code;
      item_row  <= in_target_row;
      item_col  <= in_target_col;
    end
    if (rst) begin
      fg <= tccw_pkg::RESET_FG;
    end else if (cfg_valid) begin
      fg <= cfg_data;
    end
  end

  // Cursor, sweep counter and pending write of the operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      cnt        <= '0;
      need_write <= 1'b0;
    end else begin
      if (cmd.exec) begin
        cell_addr <= lin;
        unique case (item_op)
          tccw_pkg::OP_PUT: begin
            priority if (item_char == tccw_pkg::CH_NEWLINE) begin
              cur_row    <= cur_row + RW'(1);
              cur_col    <= '0;
              need_write <= 1'b0;
            end else if (item_char == tccw_pkg::CH_TAB) begin
              need_write <= 1'b0;
              if (32'(col_tab) >= SCREEN_WIDTH) begin
                cur_row <= cur_row + RW'(1);
                cur_col <= '0;
              end else begin
                cur_col <= CW'(col_tab);
              end
            end else if (item_char == tccw_pkg::CH_BACKSPACE) begin
              if (cur_col != '0) begin
                cur_col    <= cur_col - CW'(1);
                wr_data    <= {fg, tccw_pkg::CH_BLANK};
                need_write <= 1'b1;
              end else begin
                need_write <= 1'b0;
              end
            end else begin
              wr_data    <= {fg, item_char};
              need_write <= 1'b1;
              if (32'(col_inc) >= SCREEN_WIDTH) begin
                cur_row <= cur_row + RW'(1);
                cur_col <= '0;
              end else begin
                cur_col <= CW'(col_inc);
              end
            end
          end
          tccw_pkg::OP_SET: begin
            cur_row    <= clamp_row;
            cur_col    <= clamp_col;
            need_write <= 1'b0;
          end
          tccw_pkg::OP_CLEAR: begin
            cur_row    <= '0;
            cur_col    <= '0;
            cnt        <= '0;
            need_write <= 1'b0;
          end
          tccw_pkg::OP_READ: begin
            need_write <= 1'b0;
          end
          default: begin
            need_write <= 1'b0;
          end
        endcase
      end
      if (cmd.scroll_start) begin
        cur_row <= RW'(SCREEN_HEIGHT - 1);
        cnt     <= AW'(SCREEN_WIDTH);
      end
      if (cmd.drain) begin
        cnt <= AW'(CELL_COUNT - SCREEN_WIDTH);
      end
      if (cmd.copy_rd || cmd.fill_wr) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  // Scroll copy: a cell read in one cycle is written one line higher in the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= cmd.copy_rd;
    end
    wb_addr <= cnt - AW'(SCREEN_WIDTH);
  end

  // Cell store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.copy_rd) begin
      rd_data <= cells[cnt];
    end else if (cmd.read_cell) begin
      rd_data <= cells[cell_addr];
    end
    if (wb_valid) begin
      cells[wb_addr] <= rd_data;
    end else if (cmd.write_cell && need_write) begin
      cells[cell_addr] <= wr_data;
    end else if (cmd.fill_wr) begin
      cells[cnt] <= fill_data;
    end
  end

  // Output register, free again as soon as its word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_cursor_row   <= 5'(cur_row);
      out_cursor_col   <= 7'(cur_col);
      out_cursor_index <= 11'(lin);
      if (item_op == tccw_pkg::OP_READ) begin
        out_cell_char <= rd_data[7:0];
        out_cell_attr <= {4'h0, rd_data[11:8]};
      end else begin
        out_cell_char <= '0;
        out_cell_attr <= '0;
      end
    end
  end

endmodule

### design/text_console_char_writer.sv
// Top level of the text console character writer: controller, datapath and ports.
//
// Channel   Direction  Ports                          Word
// s_*       in         s_tvalid s_tready s_tdata      one operation on the screen
//                      s_tuser
// m_*       out        m_tvalid m_tready m_tdata      cursor and cell read back
// cfg_*     in         cfg_valid cfg_ready cfg_data   foreground colour register
//
// One operation is worked at a time. The length of a clear and of a put that scrolls is
// set by the single write port of the cell store, which passes over every cell once. After
// reset a clearing pass blanks the store; s_tready stays low until it ends. A stalled
// m_tready holds only the final cycle of the next word.
module text_console_char_writer #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], target_row[12:8], target_col[19:13], zeros
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // cursor_row[4:0], cursor_col[11:5], cursor_index[22:12],
                                 // cell_char[30:23], cell_attr[38:31], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data   // foreground_color[3:0]
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;

  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [10:0] cursor_index;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  // Controller.
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  tccw_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_operation     (s_tuser),
    .in_char_code     (s_tdata[7:0]),
    .in_target_row    (s_tdata[12:8]),
    .in_target_col    (s_tdata[19:13]),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_cursor_row   (cursor_row),
    .out_cursor_col   (cursor_col),
    .out_cursor_index (cursor_index),
    .out_cell_char    (cell_char),
    .out_cell_attr    (cell_attr)
  );

  // Port packing; the register is always open for writes.
  assign s_tready  = cmd.in_ready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, cell_attr, cell_char, cursor_index, cursor_col, cursor_row};

`ifndef SYNTHESIS
  // The reset clearing pass keeps the input closed.
  a_init_closed: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input open during the clearing pass");

  // A word is worked alone: acceptance closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while one is at work");

  // The reported cursor row always lies on the screen.
  a_row_on_screen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[4:0]) < SCREEN_HEIGHT))
    else $error("cursor row beyond the screen");
`endif

endmodule

### test/text_console_char_writer_tb.sv
// Self-checking testbench of the text console character writer.
`timescale 1ns / 1ps

module text_console_char_writer_tb;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;

  // One operation word as the driver sends it.
  typedef struct {
    tccw_pkg::op_t op;
    logic [7:0]    ch;
    logic [4:0]    row;
    logic [6:0]    col;
  } console_op_t;

  // One result word: cursor after the operation and the cell read back.
  typedef struct {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] index;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } cursor_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  // Shadow copy of the screen, the cursor and the colour register.
  logic [15:0] shadow_screen [0:CELLS-1];
  int          shadow_row;
  int          shadow_col;
  logic [3:0]  shadow_fg;

  console_op_t    pending_ops[$];
  cursor_report_t expected_reports[$];

  int failures      = 0;
  int src_idle_pct  = 27;
  int sink_idle_pct = 27;
  int hold_asked    = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int hold_cycles   = 400;

  text_console_char_writer #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Blank the cells from first up to, but not including, last.
  task automatic blank_cells(input int first, input int last);
    int i;
    for (i = first; i < last; i++) shadow_screen[i] = {4'h0, shadow_fg, tccw_pkg::CH_BLANK};
  endtask

  // Work out the effect of one operation on the shadow screen and the result it gives.
  task automatic predict_console(input tccw_pkg::op_t op, input logic [7:0] ch,
                                 input logic [4:0] trow, input logic [6:0] tcol,
                                 output cursor_report_t rep);
    int          rr;
    int          cc;
    int          i;
    logic [15:0] rd_cell;
    rr      = (trow >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1 : int'(trow);
    cc      = (tcol >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : int'(tcol);
    rd_cell = '0;
    case (op)
      tccw_pkg::OP_PUT: begin
        if (ch == tccw_pkg::CH_NEWLINE) begin
          shadow_row++;
          shadow_col = 0;
        end else if (ch == tccw_pkg::CH_TAB) begin
          shadow_col += 4 - (shadow_col % 4);
          if (shadow_col >= SCREEN_WIDTH) begin
            shadow_col = 0;
            shadow_row++;
          end
        end else if (ch == tccw_pkg::CH_BACKSPACE) begin
          if (shadow_col > 0) begin
            shadow_col--;
            shadow_screen[shadow_row * SCREEN_WIDTH + shadow_col] =
              {4'h0, shadow_fg, tccw_pkg::CH_BLANK};
          end
        end else begin
          shadow_screen[shadow_row * SCREEN_WIDTH + shadow_col] = {4'h0, shadow_fg, ch};
          shadow_col++;
          if (shadow_col >= SCREEN_WIDTH) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        // A row past the bottom scrolls everything up by one line.
        if (shadow_row >= SCREEN_HEIGHT) begin
          for (i = 0; i < (SCREEN_HEIGHT - 1) * SCREEN_WIDTH; i++)
            shadow_screen[i] = shadow_screen[i + SCREEN_WIDTH];
          blank_cells((SCREEN_HEIGHT - 1) * SCREEN_WIDTH, CELLS);
          shadow_row = SCREEN_HEIGHT - 1;
        end
      end
      tccw_pkg::OP_SET: begin
        shadow_row = rr;
        shadow_col = cc;
      end
      tccw_pkg::OP_CLEAR: begin
        blank_cells(0, CELLS);
        shadow_row = 0;
        shadow_col = 0;
      end
      default: begin
        rd_cell = shadow_screen[rr * SCREEN_WIDTH + cc];
      end
    endcase
    rep.row   = 5'(shadow_row);
    rep.col   = 7'(shadow_col);
    rep.index = 11'(shadow_row * SCREEN_WIDTH + shadow_col);
    rep.ch    = rd_cell[7:0];
    rep.attr  = rd_cell[15:8];
  endtask

  function automatic console_op_t make_op(tccw_pkg::op_t op, logic [7:0] ch, logic [4:0] row,
                                          logic [6:0] col);
    console_op_t w;
    w.op  = op;
    w.ch  = ch;
    w.row = row;
    w.col = col;
    return w;
  endfunction

  // Random operation, weighted towards the bottom rows and line ends where wraps and
  // scrolls happen, with fully random rows and columns mixed in.
  function automatic console_op_t random_op();
    console_op_t w;
    int          pick;
    int          sel;
    pick  = $urandom_range(0, 99);
    w.ch  = 8'($urandom_range(0, 255));
    w.row = 5'($urandom_range(0, 31));
    w.col = 7'($urandom_range(0, 127));
    if (pick < 58) begin
      w.op = tccw_pkg::OP_PUT;
      sel  = $urandom_range(0, 99);
      if (sel < 10) w.ch = tccw_pkg::CH_NEWLINE;
      else if (sel < 20) w.ch = tccw_pkg::CH_TAB;
      else if (sel < 30) w.ch = tccw_pkg::CH_BACKSPACE;
    end else if (pick < 72) begin
      w.op = tccw_pkg::OP_SET;
      if ($urandom_range(0, 1)) begin
        w.row = 5'($urandom_range(21, 24));
        w.col = $urandom_range(0, 1) ? 7'($urandom_range(0, 12)) : 7'($urandom_range(66, 79));
      end
    end else if (pick < 74) begin
      w.op = tccw_pkg::OP_CLEAR;
    end else begin
      w.op = tccw_pkg::OP_READ;
      if ($urandom_range(0, 1)) begin
        w.row = 5'($urandom_range(18, 24));
        w.col = $urandom_range(0, 1) ? 7'($urandom_range(0, 15)) : 7'($urandom_range(64, 79));
      end
    end
    return w;
  endfunction

  // Sender: offers pending words, predicts each one as it is accepted.
  always @(posedge clk) begin
    cursor_report_t rep;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_console(tccw_pkg::op_t'(s_tuser), s_tdata[7:0], s_tdata[12:8],
                        s_tdata[19:13], rep);
        expected_reports.push_back(rep);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tuser  <= pending_ops[0].op;
          s_tdata  <= {4'h0, pending_ops[0].col, pending_ops[0].row, pending_ops[0].ch};
          void'(pending_ops.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      failures++;
    end
  endfunction

  // Receiver: random stalls, a long hold-off on request, and the result check.
  always @(posedge clk) begin
    cursor_report_t rep;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result word with no operation outstanding: %h", m_tdata);
          failures++;
        end else begin
          rep = expected_reports.pop_front();
          check_field("cursor_row", rep.row, m_tdata[4:0]);
          check_field("cursor_col", rep.col, m_tdata[11:5]);
          check_field("cursor_index", rep.index, m_tdata[22:12]);
          check_field("cell_char", rep.ch, m_tdata[30:23]);
          check_field("cell_attr", rep.attr, m_tdata[38:31]);
        end
      end
      if (hold_taken != hold_asked) begin
        hold_taken <= hold_asked;
        hold_left  <= hold_cycles;
        m_tready   <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Wait until every queued word has gone in and every result has come back.
  task automatic wait_drained();
    while (pending_ops.size() > 0 || s_tvalid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write the foreground colour register while the block is idle.
  task automatic write_colour(input logic [3:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_fg = value;
  endtask

  task automatic queue_random(input int count);
    int i;
    for (i = 0; i < count; i++) pending_ops.push_back(random_op());
  endtask

  // Main sequence: directed words, then random phases under several colours.
  initial begin
    shadow_row = 0;
    shadow_col = 0;
    shadow_fg  = tccw_pkg::RESET_FG;
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {8'h0F, tccw_pkg::CH_BLANK};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset blanks, extreme bytes, control bytes, clamps, wraps and scrolls.
    pending_ops.push_back(make_op(tccw_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, 8'h41, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, 8'hFF, 5'd31, 7'd127));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, 8'h00, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_READ, 8'h00, 5'd0, 7'd2));
    pending_ops.push_back(make_op(tccw_pkg::OP_READ, 8'h00, 5'd31, 7'd127));
    pending_ops.push_back(make_op(tccw_pkg::OP_SET, 8'h00, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_SET, 8'h00, 5'd31, 7'd127));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, 8'h5A, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_READ, 8'h00, 5'd23, 7'd79));
    pending_ops.push_back(make_op(tccw_pkg::OP_SET, 8'h00, 5'd24, 7'd77));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_READ, 8'h00, 5'd22, 7'd79));
    pending_ops.push_back(make_op(tccw_pkg::OP_SET, 8'h00, 5'd5, 7'd76));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, tccw_pkg::CH_NEWLINE, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_SET, 8'h00, 5'd24, 7'd10));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, tccw_pkg::CH_NEWLINE, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_CLEAR, 8'h00, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_PUT, 8'h7E, 5'd0, 7'd0));
    pending_ops.push_back(make_op(tccw_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
    wait_drained();

    // Black foreground, ordinary idling on both sides.
    write_colour(4'h0);
    queue_random(75);
    wait_drained();

    // White foreground, a long stretch without any idling.
    write_colour(4'hF);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    queue_random(75);
    wait_drained();

    // Receiver holds off while the sender keeps offering words.
    write_colour(4'($urandom_range(0, 15)));
    sink_idle_pct = 27;
    queue_random(75);
    hold_asked++;
    wait_drained();

    src_idle_pct = 27;
    write_colour(4'($urandom_range(0, 15)));
    queue_random(75);
    wait_drained();

    if (failures == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule
